/* sv/vex_instruction_decoder_macros.svh */
// Assertion macros for the VEX instruction decoder.
`ifndef VEX_INSTRUCTION_DECODER_MACROS_SVH
`define VEX_INSTRUCTION_DECODER_MACROS_SVH
`ifndef SYNTHESIS
`define VID_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define VID_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define VID_ASSERT(label, clk, rst_n, prop, msg)
`define VID_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

/* sv/vid_pkg.sv */
// Shared types and constants of the VEX instruction decoder.
package vid_pkg;
    localparam int MAX_PREFIXES = 4;
    localparam int PfxW = $clog2(MAX_PREFIXES + 1);

    typedef enum logic [3:0] {
        PH_IDLE, PH_PREFIX, PH_C5_B1, PH_C4_B1, PH_C4_B2,
        PH_OPCODE, PH_MODRM, PH_SIB, PH_DISP, PH_IMM
    } phase_t;

    // outcome of one byte: carry on, instruction complete, window failed, byte ignored
    typedef enum logic [1:0] {
        GO_ON, GO_DONE, GO_FAIL, GO_SKIP
    } step_t;

    // trailing byte after the operand
    typedef enum logic [1:0] {
        IK_NONE, IK_IMM8, IK_IS4
    } imm_kind_t;

    typedef struct packed {
        logic        decode_ok;
        logic [3:0]  insn_length;
        logic [11:0] vex_info;
        logic [7:0]  opcode_byte;
        logic [1:0]  modrm_mode;
        logic [3:0]  reg_number;
        logic [10:0] operand_info;
        logic [7:0]  base_and_index;
        logic [31:0] displacement;
        logic [7:0]  immediate;
        logic [5:0]  imm_info;
    } result_t;

    localparam int ResW = $bits(result_t);
    localparam int QDepth = 2;
    localparam int QAw = $clog2(QDepth);
endpackage

/* sv/vid_front.sv */
// Front part: byte-serial decode of one instruction window into a result.
module vid_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [7:0]           byte_value,
    input  logic                 first_byte,
    input  logic                 last_byte,
    output logic                 res_valid,
    output vid_pkg::result_t     res
);
    vid_pkg::phase_t phase_reg, phase_next;
    logic [vid_pkg::PfxW-1:0] pfx_reg, pfx_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [11:0] vex_reg, vex_next;
    logic [2:0]  rex_reg, rex_next;
    logic [7:0]  opc_reg, opc_next, modrm_reg, modrm_next;
    logic [31:0] disp_reg, disp_next;
    logic [2:0]  dleft_reg, dleft_next;
    logic        dwide_reg, dwide_next;
    vid_pkg::imm_kind_t ik_reg, ik_next;
    logic [10:0] op_reg, op_next;
    logic [7:0]  bi_reg, bi_next;

    vid_pkg::step_t r;
    logic [4:0] cnt_inc;
    logic [1:0] mode;
    logic [3:0] raw;
    logic [7:0] imm;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= vid_pkg::PH_IDLE;
            pfx_reg <= '0; cnt_reg <= '0; vex_reg <= '0; rex_reg <= '0;
            opc_reg <= '0; modrm_reg <= '0; disp_reg <= '0; dleft_reg <= '0;
            dwide_reg <= 1'b0; ik_reg <= vid_pkg::IK_NONE; op_reg <= '0; bi_reg <= '0;
        end
        else if (in_valid)
        begin
            phase_reg <= phase_next;
            pfx_reg <= pfx_next; cnt_reg <= cnt_next; vex_reg <= vex_next;
            rex_reg <= rex_next; opc_reg <= opc_next; modrm_reg <= modrm_next;
            disp_reg <= disp_next; dleft_reg <= dleft_next;
            dwide_reg <= dwide_next; ik_reg <= ik_next; op_reg <= op_next;
            bi_reg <= bi_next;
        end
    end

    // Per-byte decode
    always_comb
    begin
        vid_pkg::phase_t ph;
        ph = phase_reg;
        pfx_next = pfx_reg; cnt_next = cnt_reg; vex_next = vex_reg;
        rex_next = rex_reg; opc_next = opc_reg; modrm_next = modrm_reg;
        disp_next = disp_reg; dleft_next = dleft_reg; dwide_next = dwide_reg;
        ik_next = ik_reg; op_next = op_reg; bi_next = bi_reg;
        imm = 8'h00;
        r = vid_pkg::GO_ON;
        raw = byte_value[6:3];
        if (first_byte)
        begin
            ph = vid_pkg::PH_PREFIX;
            pfx_next = '0; cnt_next = '0; vex_next = '0; rex_next = '0;
            opc_next = '0; modrm_next = '0; disp_next = '0; dleft_next = '0;
            dwide_next = 1'b0; ik_next = vid_pkg::IK_NONE; op_next = '0; bi_next = '0;
        end
        mode = modrm_next[7:6];
        cnt_inc = {1'b0, cnt_next} + 5'd1;
        cnt_next = cnt_inc[3:0];
        if (ph == vid_pkg::PH_IDLE)
            r = vid_pkg::GO_SKIP;  // no window open
        else if (cnt_inc > 5'd15)
            r = vid_pkg::GO_FAIL;
        else
        begin
            case (ph)
                vid_pkg::PH_PREFIX:
                begin
                    if ((byte_value inside {8'h2E, 8'h36, 8'h3E, 8'h26, 8'h64, 8'h65,
                         8'h67}) && ({1'b0, pfx_next} < (vid_pkg::PfxW+1)'(vid_pkg::MAX_PREFIXES)))
                        pfx_next = pfx_next + 1'b1;
                    else if (byte_value == 8'hC5) ph = vid_pkg::PH_C5_B1;
                    else if (byte_value == 8'hC4) ph = vid_pkg::PH_C4_B1;
                    else r = vid_pkg::GO_FAIL;
                end
                vid_pkg::PH_C5_B1:
                begin
                    vex_next = {2'b01, byte_value[1:0], (raw != 4'hF), ~raw,
                                byte_value[2], 2'b00};
                    rex_next = {~byte_value[7], 2'b00};
                    ph = vid_pkg::PH_OPCODE;
                end
                vid_pkg::PH_C4_B1:
                begin
                    if (byte_value[4:0] inside {[5'd1:5'd3]})
                    begin
                        vex_next = {byte_value[1:0], 9'd0, 1'b1};
                        rex_next = ~byte_value[7:5];
                        ph = vid_pkg::PH_C4_B2;
                    end
                    else r = vid_pkg::GO_FAIL;
                end
                vid_pkg::PH_C4_B2:
                begin
                    vex_next = {vex_next[11:10], byte_value[1:0], (raw != 4'hF), ~raw,
                                byte_value[2], byte_value[7], 1'b1};
                    ph = vid_pkg::PH_OPCODE;
                end
                vid_pkg::PH_OPCODE:
                begin
                    opc_next = byte_value;
                    ik_next = vid_pkg::IK_NONE;
                    if (vex_next[11:10] == 2'd1)
                    begin
                        if (byte_value inside {8'hC2, 8'h70, 8'hC6, 8'hC4, 8'hC5, 8'h71,
                                               8'h72, 8'h73})
                            ik_next = vid_pkg::IK_IMM8;
                    end
                    else if (vex_next[11:10] == 2'd3)
                        ik_next = (byte_value inside {[8'h4A:8'h4C]}) ? vid_pkg::IK_IS4 :
                                                                        vid_pkg::IK_IMM8;
                    ph = vid_pkg::PH_MODRM;
                end
                vid_pkg::PH_MODRM:
                begin
                    modrm_next = byte_value;
                    if (byte_value[7:6] == 2'd3)
                    begin
                        op_next = {7'd0, rex_next[0], byte_value[2:0]};
                        ph = vid_pkg::PH_DISP; dleft_next = '0;
                    end
                    else if (byte_value[2:0] == 3'd4)
                    begin
                        op_next = 11'h010;
                        ph = vid_pkg::PH_SIB;
                    end
                    else
                    begin
                        op_next = 11'h110;
                        if (byte_value[2:0] == 3'd5 && byte_value[7:6] == 2'd0)
                        begin
                            op_next = 11'h1D0;
                            dwide_next = 1'b1; dleft_next = 3'd4;
                        end
                        else
                        begin
                            bi_next = {4'd0, rex_next[0], byte_value[2:0]};
                            dwide_next = (byte_value[7:6] == 2'd2);
                            dleft_next = (byte_value[7:6] == 2'd2) ? 3'd4 :
                                         (byte_value[7:6] == 2'd1) ? 3'd1 : 3'd0;
                        end
                        ph = vid_pkg::PH_DISP;
                    end
                    if (ph == vid_pkg::PH_DISP && dleft_next == 3'd0)
                    begin
                        if (ik_next != vid_pkg::IK_NONE) ph = vid_pkg::PH_IMM;
                        else r = vid_pkg::GO_DONE;
                    end
                end
                vid_pkg::PH_SIB:
                begin
                    op_next = op_next | 11'h020 | {byte_value[7:6], 9'd0};
                    if (byte_value[5:3] == 3'd4 && !rex_next[1])
                        op_next = op_next | 11'h100;
                    else
                        bi_next = {rex_next[1], byte_value[5:3], bi_next[3:0]};
                    if (byte_value[2:0] == 3'd5 && mode == 2'd0)
                    begin
                        op_next = op_next | 11'h080;
                        dwide_next = 1'b1; dleft_next = 3'd4;
                    end
                    else
                    begin
                        bi_next = {bi_next[7:4], rex_next[0], byte_value[2:0]};
                        dwide_next = (mode == 2'd2);
                        dleft_next = (mode == 2'd2) ? 3'd4 : (mode == 2'd1) ? 3'd1 : 3'd0;
                    end
                    ph = vid_pkg::PH_DISP;
                    if (dleft_next == 3'd0)
                    begin
                        if (ik_next != vid_pkg::IK_NONE) ph = vid_pkg::PH_IMM;
                        else r = vid_pkg::GO_DONE;
                    end
                end
                vid_pkg::PH_DISP:
                begin
                    if (!dwide_next)
                    begin
                        disp_next = {{24{byte_value[7]}}, byte_value};
                        dleft_next = 3'd0;
                    end
                    else
                    begin
                        disp_next = {byte_value, disp_next[31:8]};
                        dleft_next = dleft_next - 3'd1;
                    end
                    if (dleft_next == 3'd0)
                    begin
                        if (ik_next != vid_pkg::IK_NONE) ph = vid_pkg::PH_IMM;
                        else r = vid_pkg::GO_DONE;
                    end
                end
                vid_pkg::PH_IMM:
                begin
                    imm = byte_value;
                    r = vid_pkg::GO_DONE;
                end
                default: r = vid_pkg::GO_FAIL;
            endcase
        end
        if (r == vid_pkg::GO_ON && last_byte) r = vid_pkg::GO_FAIL;
        if (r == vid_pkg::GO_SKIP)
            phase_next = phase_reg;
        else if (r != vid_pkg::GO_ON)
            phase_next = vid_pkg::PH_IDLE;
        else
            phase_next = ph;
        if (r == vid_pkg::GO_SKIP)
        begin
            cnt_next = cnt_reg;
        end
    end

    // Result assembly
    always_comb
    begin
        res_valid = in_valid && (r == vid_pkg::GO_DONE || r == vid_pkg::GO_FAIL);
        res = '0;
        if (r == vid_pkg::GO_DONE)
        begin
            res.decode_ok = 1'b1;
            res.insn_length = cnt_next;
            res.vex_info = vex_next;
            res.opcode_byte = opc_next;
            res.modrm_mode = modrm_next[7:6];
            res.reg_number = {rex_next[2], modrm_next[5:3]};
            res.operand_info = op_next;
            res.base_and_index = bi_next;
            res.displacement = disp_next;
            if (ik_next != vid_pkg::IK_NONE)
            begin
                res.immediate = imm;
                res.imm_info = {(ik_next == vid_pkg::IK_IS4) ? imm[7:4] : 4'd0,
                                ik_next == vid_pkg::IK_IS4, 1'b1};
            end
        end
    end
endmodule

/* sv/vid_queue.sv */
// Result queue between the decode front and the output side.
module vid_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  vid_pkg::result_t     wr_data,
    output logic                 q_full,
    input  logic                 rd_en,
    output logic                 q_empty,
    output vid_pkg::result_t     rd_data
);
    vid_pkg::result_t mem_reg [vid_pkg::QDepth];
    logic [vid_pkg::QAw-1:0] wp_reg, rp_reg;
    logic [vid_pkg::QAw:0]   cnt_reg;

    assign q_full  = (cnt_reg == (vid_pkg::QAw+1)'(vid_pkg::QDepth));
    assign q_empty = (cnt_reg == '0);
    assign rd_data = mem_reg[rp_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (wr_en) mem_reg[wp_reg] <= wr_data;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            if (wr_en) wp_reg <= wp_reg + 1'b1;
            if (rd_en) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (vid_pkg::QAw+1)'(wr_en) - (vid_pkg::QAw+1)'(rd_en);
        end
    end

    `include "vex_instruction_decoder_macros.svh"
    `VID_NEVER(a_no_overflow, clk, rst_n, wr_en && q_full && !rd_en, "queue overflow")
    `VID_NEVER(a_no_underflow, clk, rst_n, rd_en && q_empty, "queue underflow")
    `VID_ASSERT(a_count_step, clk, rst_n, (wr_en && !rd_en) |=> !q_empty, "count lost")
endmodule

/* sv/vex_instruction_decoder.sv */
// Latency: a result is held in the result queue from the cycle after the transaction that ends its window.
// Throughput: one byte per cycle while full is low; the front keeps taking bytes while results wait, until full rises.
// full rises only when two results wait in the result queue unpopped.
// Reset (rst_n low, asynchronous) empties the queue and closes any open window.
// Top level of the VEX instruction decoder.
module vex_instruction_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  byte_value,
    input  logic        first_byte,
    input  logic        last_byte,
    output logic        empty,
    input  logic        pop,
    output logic        decode_ok,
    output logic [3:0]  insn_length,
    output logic [11:0] vex_info,
    output logic [7:0]  opcode_byte,
    output logic [1:0]  modrm_mode,
    output logic [3:0]  reg_number,
    output logic [10:0] operand_info,
    output logic [7:0]  base_and_index,
    output logic signed [31:0] displacement,
    output logic [7:0]  immediate,
    output logic [5:0]  imm_info
);
    logic accept, res_valid;
    vid_pkg::result_t res, q_out;

    assign accept = push && !full;

    vid_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(accept), .byte_value(byte_value),
        .first_byte(first_byte), .last_byte(last_byte),
        .res_valid(res_valid), .res(res)
    );

    vid_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_en(res_valid), .wr_data(res), .q_full(full),
        .rd_en(pop && !empty), .q_empty(empty), .rd_data(q_out)
    );

    assign decode_ok      = q_out.decode_ok;
    assign insn_length    = q_out.insn_length;
    assign vex_info       = q_out.vex_info;
    assign opcode_byte    = q_out.opcode_byte;
    assign modrm_mode     = q_out.modrm_mode;
    assign reg_number     = q_out.reg_number;
    assign operand_info   = q_out.operand_info;
    assign base_and_index = q_out.base_and_index;
    assign displacement   = q_out.displacement;
    assign immediate      = q_out.immediate;
    assign imm_info       = q_out.imm_info;
endmodule

/* verif/vex_instruction_decoder_test.sv */
// Self-checking bench for the VEX instruction decoder: byte-stream stimulus, scoreboard, checks.
module vex_instruction_decoder_test;

    localparam int LimitCycles = 20000;

    typedef struct packed {
        logic [7:0] b;
        logic       f;
        logic       l;
    } byte_txn_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  byte_value;
    logic        first_byte;
    logic        last_byte;
    logic        empty;
    logic        pop;
    logic        decode_ok;
    logic [3:0]  insn_length;
    logic [11:0] vex_info;
    logic [7:0]  opcode_byte;
    logic [1:0]  modrm_mode;
    logic [3:0]  reg_number;
    logic [10:0] operand_info;
    logic [7:0]  base_and_index;
    logic signed [31:0] displacement;
    logic [7:0]  immediate;
    logic [5:0]  imm_info;

    vex_instruction_decoder uut (.*);

    // predictor state
    vid_pkg::phase_t    ph;
    int                 n_pfx, n_bytes, disp_left;
    vid_pkg::imm_kind_t imm_kind;
    logic [11:0] vexf;
    logic [2:0]  rex;
    logic [7:0]  opc, modrm, immb;
    logic [31:0] dispv;
    logic        disp_wide;
    logic [10:0] opnd;
    logic [7:0]  bidx;

    byte_txn_t          byte_queue[$];
    vid_pkg::result_t   expected_results[$];
    int          errors = 0;
    int          sent = 0;
    bit          quiet_end = 0;
    bit          drain_req = 0;
    bit          hold_req = 0;
    int          idle_cycles = 0;

    function automatic void clear_window();
        n_pfx = 0; n_bytes = 0; vexf = '0; rex = '0; opc = '0; modrm = '0;
        dispv = '0; disp_left = 0; disp_wide = 0; imm_kind = vid_pkg::IK_NONE;
        opnd = '0; bidx = '0; immb = '0;
    endfunction

    function automatic void take_vvvv(logic [7:0] b);
        logic [3:0] raw;
        raw = b[6:3];
        vexf[6:3] = ~raw;
        if (raw != 4'hF) vexf[7] = 1'b1;
        if (b[2]) vexf[2] = 1'b1;
        vexf[9:8] = b[1:0];
    endfunction

    function automatic vid_pkg::step_t after_operand();
        if (imm_kind != vid_pkg::IK_NONE)
        begin
            ph = vid_pkg::PH_IMM;
            return vid_pkg::GO_ON;
        end
        return vid_pkg::GO_DONE;
    endfunction

    function automatic vid_pkg::step_t start_disp(logic [1:0] md, bit wide);
        if (wide || md == 2)
        begin
            disp_wide = 1; disp_left = 4;
        end
        else if (md == 1)
        begin
            disp_wide = 0; disp_left = 1;
        end
        else
            return after_operand();
        ph = vid_pkg::PH_DISP;
        return vid_pkg::GO_ON;
    endfunction

    function automatic vid_pkg::step_t decode_byte(logic [7:0] b);
        logic [1:0] md;
        logic [4:0] mp;
        logic [2:0] rm, ix, bs;
        bit wide;
        md = modrm[7:6];
        case (ph)
            vid_pkg::PH_PREFIX:
            begin
                if ((b == 8'h2E || b == 8'h36 || b == 8'h3E || b == 8'h26 || b == 8'h64 ||
                     b == 8'h65 || b == 8'h67) && n_pfx < vid_pkg::MAX_PREFIXES)
                begin
                    n_pfx++;
                    return vid_pkg::GO_ON;
                end
                if (b == 8'hC5) begin ph = vid_pkg::PH_C5_B1; return vid_pkg::GO_ON; end
                if (b == 8'hC4) begin ph = vid_pkg::PH_C4_B1; return vid_pkg::GO_ON; end
                return vid_pkg::GO_FAIL;
            end
            vid_pkg::PH_C5_B1:
            begin
                vexf = 12'h400;
                rex = b[7] ? 3'b000 : 3'b100;
                take_vvvv(b);
                ph = vid_pkg::PH_OPCODE;
                return vid_pkg::GO_ON;
            end
            vid_pkg::PH_C4_B1:
            begin
                mp = b[4:0];
                if (mp < 5'd1 || mp > 5'd3) return vid_pkg::GO_FAIL;
                vexf = {mp[1:0], 10'h001};
                rex = ~b[7:5];
                ph = vid_pkg::PH_C4_B2;
                return vid_pkg::GO_ON;
            end
            vid_pkg::PH_C4_B2:
            begin
                if (b[7]) vexf[1] = 1'b1;
                take_vvvv(b);
                ph = vid_pkg::PH_OPCODE;
                return vid_pkg::GO_ON;
            end
            vid_pkg::PH_OPCODE:
            begin
                opc = b;
                imm_kind = vid_pkg::IK_NONE;
                if (vexf[11:10] == 2'd1)
                begin
                    if (b == 8'hC2 || b == 8'h70 || b == 8'hC6 || b == 8'hC4 ||
                        b == 8'hC5 || b == 8'h71 || b == 8'h72 || b == 8'h73)
                        imm_kind = vid_pkg::IK_IMM8;
                end
                else if (vexf[11:10] == 2'd3)
                    imm_kind = (b >= 8'h4A && b <= 8'h4C) ? vid_pkg::IK_IS4 : vid_pkg::IK_IMM8;
                ph = vid_pkg::PH_MODRM;
                return vid_pkg::GO_ON;
            end
            vid_pkg::PH_MODRM:
            begin
                rm = b[2:0];
                modrm = b;
                md = b[7:6];
                if (md == 3)
                begin
                    opnd = {7'd0, rex[0], rm};
                    return after_operand();
                end
                opnd = 11'h010;
                if (rm == 4)
                begin
                    ph = vid_pkg::PH_SIB;
                    return vid_pkg::GO_ON;
                end
                opnd |= 11'h100;
                if (rm == 5 && md == 0)
                begin
                    opnd |= 11'h0C0;
                    return start_disp(md, 1'b1);
                end
                bidx = {4'd0, rex[0], rm};
                return start_disp(md, 1'b0);
            end
            vid_pkg::PH_SIB:
            begin
                ix = b[5:3];
                bs = b[2:0];
                wide = 0;
                opnd |= {b[7:6], 9'h020};
                if (ix == 4 && rex[1] == 0)
                    opnd |= 11'h100;
                else
                    bidx[7:4] = {rex[1], ix};
                if (bs == 5 && md == 0)
                begin
                    opnd |= 11'h080;
                    wide = 1;
                end
                else
                    bidx[3:0] = {rex[0], bs};
                return start_disp(md, wide);
            end
            vid_pkg::PH_DISP:
            begin
                if (!disp_wide)
                begin
                    dispv = {{24{b[7]}}, b};
                    disp_left = 0;
                    return after_operand();
                end
                dispv = {b, dispv[31:8]};
                disp_left--;
                if (disp_left == 0) return after_operand();
                return vid_pkg::GO_ON;
            end
            vid_pkg::PH_IMM:
            begin
                immb = b;
                return vid_pkg::GO_DONE;
            end
            default: return vid_pkg::GO_FAIL;
        endcase
    endfunction

    // model one accepted byte; push any result onto the expectation queue
    function automatic void predict_byte(byte_txn_t t);
        vid_pkg::step_t r;
        vid_pkg::result_t res;
        if (t.f)
        begin
            clear_window();
            ph = vid_pkg::PH_PREFIX;
        end
        else if (ph == vid_pkg::PH_IDLE)
            return;
        n_bytes++;
        if (n_bytes > 15) r = vid_pkg::GO_FAIL;
        else r = decode_byte(t.b);
        if (r == vid_pkg::GO_ON && t.l) r = vid_pkg::GO_FAIL;
        if (r == vid_pkg::GO_ON) return;
        res = '0;
        if (r == vid_pkg::GO_DONE)
        begin
            res.decode_ok = 1'b1;
            res.insn_length = n_bytes[3:0];
            res.vex_info = vexf;
            res.opcode_byte = opc;
            res.modrm_mode = modrm[7:6];
            res.reg_number = {rex[2], modrm[5:3]};
            res.operand_info = opnd;
            res.base_and_index = bidx;
            res.displacement = dispv;
            if (imm_kind != vid_pkg::IK_NONE)
            begin
                res.immediate = immb;
                res.imm_info = 6'd1;
                if (imm_kind == vid_pkg::IK_IS4) res.imm_info = {immb[7:4], 2'b11};
            end
        end
        expected_results.push_back(res);
        ph = vid_pkg::PH_IDLE;
    endfunction

    // stimulus builders
    task automatic add_byte(logic [7:0] b, int f, int l);
        byte_txn_t t;
        t.b = b; t.f = (f != 0); t.l = (l != 0);
        byte_queue.push_back(t);
    endtask

    function automatic logic [7:0] pick_prefix();
        logic [7:0] p[7] = '{8'h2E, 8'h36, 8'h3E, 8'h26, 8'h64, 8'h65, 8'h67};
        return p[$urandom_range(6)];
    endfunction

    // map 2 has no opcode with a trailing byte, so it only gets random opcodes
    function automatic logic [7:0] pick_opcode(int mp);
        logic [7:0] o[11] = '{8'hC2, 8'h70, 8'hC6, 8'hC4, 8'hC5, 8'h71, 8'h72, 8'h73,
                              8'h4A, 8'h4B, 8'h4C};
        if (mp != 2 && $urandom_range(1)) return o[$urandom_range(10)];
        return 8'($urandom);
    endfunction

    // an instruction with random content and two trailing random bytes, sometimes cut short or corrupted
    task automatic add_insn(int npfx, int three, int mp, logic [7:0] md_byte, int cut);
        logic [7:0] bytes[$];
        int i;
        int ndisp;
        bit imm;
        logic [7:0] op, sib;
        for (i = 0; i < npfx; i++) bytes.push_back(pick_prefix());
        if (three != 0)
        begin
            bytes.push_back(8'hC4);
            bytes.push_back({3'($urandom), 5'(mp)});
        end
        else
        begin
            bytes.push_back(8'hC5);
            mp = 1;
        end
        bytes.push_back(8'($urandom));
        op = pick_opcode(mp);
        bytes.push_back(op);
        bytes.push_back(md_byte);
        sib = 8'($urandom);
        ndisp = 0;
        if (md_byte[7:6] != 3 && md_byte[2:0] == 4) bytes.push_back(sib);
        if (md_byte[7:6] == 1) ndisp = 1;
        else if (md_byte[7:6] == 2) ndisp = 4;
        else if (md_byte[7:6] == 0 && md_byte[2:0] == 5) ndisp = 4;
        else if (md_byte[7:6] == 0 && md_byte[2:0] == 4 && sib[2:0] == 5) ndisp = 4;
        for (i = 0; i < ndisp; i++) bytes.push_back(8'($urandom));
        imm = 1;
        for (i = 0; i < 1 + imm; i++) bytes.push_back(8'($urandom));
        if (cut > 0 && cut < bytes.size())
            bytes = bytes[0:cut-1];
        for (i = 0; i < bytes.size(); i++)
            add_byte(bytes[i], i == 0, i == bytes.size() - 1 && $urandom_range(1));
    endtask

    // clock and reset
    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
    end

    // driver
    int gap_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 0; byte_value <= '0; first_byte <= 0; last_byte <= 0;
            gap_left = 0;
        end
        else
        begin
            if (push && !full)
            begin
                predict_byte({byte_value, first_byte, last_byte});
                void'(byte_queue.pop_front());
                sent++;
            end
            if (!(push && full))
            begin
                if (gap_left > 0) gap_left--;
                else if (!quiet_end && $urandom_range(9) == 0) gap_left = $urandom_range(1, 5);
                if (byte_queue.size() > 0 && gap_left == 0 && !drain_req)
                begin
                    push <= 1;
                    {byte_value, first_byte, last_byte} <= byte_queue[0];
                end
                else
                    push <= 0;
            end
        end
    end

    // monitor and receiver
    int stall_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 0;
            stall_left = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time,
                        {decode_ok, insn_length, vex_info, opcode_byte, modrm_mode, reg_number,
                         operand_info, base_and_index, displacement, immediate, imm_info});
                    errors++;
                end
                else
                begin
                    vid_pkg::result_t e;
                    e = expected_results.pop_front();
                    if (decode_ok !== e.decode_ok) begin errors++;
                        $display("%0t: decode_ok exp %h got %h", $time, e.decode_ok, decode_ok); end
                    if (insn_length !== e.insn_length) begin errors++;
                        $display("%0t: insn_length exp %h got %h", $time, e.insn_length,
                                 insn_length); end
                    if (vex_info !== e.vex_info) begin errors++;
                        $display("%0t: vex_info exp %h got %h", $time, e.vex_info, vex_info); end
                    if (opcode_byte !== e.opcode_byte) begin errors++;
                        $display("%0t: opcode_byte exp %h got %h", $time, e.opcode_byte,
                                 opcode_byte); end
                    if (modrm_mode !== e.modrm_mode) begin errors++;
                        $display("%0t: modrm_mode exp %h got %h", $time, e.modrm_mode,
                                 modrm_mode); end
                    if (reg_number !== e.reg_number) begin errors++;
                        $display("%0t: reg_number exp %h got %h", $time, e.reg_number,
                                 reg_number); end
                    if (operand_info !== e.operand_info) begin errors++;
                        $display("%0t: operand_info exp %h got %h", $time, e.operand_info,
                                 operand_info); end
                    if (base_and_index !== e.base_and_index) begin errors++;
                        $display("%0t: base_and_index exp %h got %h", $time, e.base_and_index,
                                 base_and_index); end
                    if (displacement !== e.displacement) begin errors++;
                        $display("%0t: displacement exp %h got %h", $time, e.displacement,
                                 displacement); end
                    if (immediate !== e.immediate) begin errors++;
                        $display("%0t: immediate exp %h got %h", $time, e.immediate,
                                 immediate); end
                    if (imm_info !== e.imm_info) begin errors++;
                        $display("%0t: imm_info exp %h got %h", $time, e.imm_info, imm_info); end
                end
            end
            if (hold_req)
            begin
                pop <= 0;
                stall_left = 60;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                pop <= 0;
            end
            else if (!quiet_end && $urandom_range(7) == 0)
            begin
                stall_left = $urandom_range(0, 4);
                pop <= 0;
            end
            else
                pop <= 1;
        end
    end

    // watchdog on accepted transactions
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > LimitCycles)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // stimulus sequence and end of run
    initial
    begin
        int i, k;
        int lim;
        ph = vid_pkg::PH_IDLE;
        clear_window();
        // directed: stray idle byte, several addressing forms, bad bytes, limits
        add_byte(8'hFF, 0, 0);
        add_insn(0, 0, 1, 8'hC1, 0);
        add_insn(4, 1, 3, 8'h04, 0);
        add_insn(1, 1, 2, 8'h05, 0);
        add_insn(0, 1, 1, 8'h44, 0);
        add_insn(2, 1, 3, 8'h8C, 0);
        add_insn(0, 1, 2, 8'hBF, 0);
        add_insn(3, 0, 1, 8'h00, 3);
        add_byte(8'h90, 1, 0);
        add_byte(8'hC4, 1, 0); add_byte(8'h00, 0, 0);
        add_byte(8'hC4, 1, 0); add_byte(8'hFF, 0, 0);
        for (i = 0; i < 5; i++) add_byte(8'h2E, i == 0, 0);
        add_byte(8'hC5, 0, 0);
        for (i = 0; i < 16; i++) add_byte(i == 0 ? 8'h26 : 8'h3E, i == 0, 0);
        add_byte(8'h12, 0, 0);
        add_insn(0, 0, 1, 8'hC0, 0);
        add_byte(8'h00, 0, 1);

        // random: mostly whole instructions with random content
        while (byte_queue.size() < 950)
        begin
            k = $urandom_range(9);
            if (k == 0)
                add_byte(8'($urandom), $urandom_range(1), $urandom_range(1));
            else
                add_insn($urandom_range(4), $urandom_range(1), $urandom_range(1, 3),
                         8'($urandom), k == 1 ? $urandom_range(1, 8) : 0);
        end

        wait (rst_n);
        // long receiver hold-off while the sender keeps offering
        wait (sent > 150);
        @(posedge clk); hold_req <= 1;
        @(posedge clk); hold_req <= 0;
        // sender pause until everything has drained
        wait (sent > 500);
        @(posedge clk); drain_req <= 1;
        wait (expected_results.size() == 0);
        @(posedge clk); drain_req <= 0;
        wait (sent > 800);
        quiet_end = 1;
        wait (byte_queue.size() == 0);
        lim = 0;
        while (expected_results.size() != 0 && lim < LimitCycles)
        begin
            @(posedge clk);
            lim++;
        end
        repeat (5) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+sv
sv/vid_pkg.sv
sv/vid_front.sv
sv/vid_queue.sv
sv/vex_instruction_decoder.sv
verif/vex_instruction_decoder_test.sv
